// ----- hw/rtl/ntct_pkg.sv -----
// Package: constants, resistance table and status codes of the NTC temperature unit.
package ntct_pkg;

   localparam int ROM_SIZE     = 136;
   localparam int BASE_DEGREE  = -30;
   localparam int SERIES_RESET = 8250;

   typedef enum logic [1:0] {
      STAT_IN_TABLE = 2'd0,
      STAT_COLD     = 2'd1,
      STAT_HOT      = 2'd2,
      STAT_ZERO     = 2'd3
   } status_type;

   // Thermistor resistance in ohms, one entry per degree from -30 C upward
   localparam logic [16:0] RES_ROM [ROM_SIZE] = '{
      17'd113347,17'd107565,17'd102116,17'd96978,17'd92132,17'd87559,17'd83242,
      17'd79166,17'd75316,17'd71677,17'd68237,17'd64991,17'd61919,17'd59011,
      17'd56258,17'd53650,17'd51178,17'd48835,17'd46613,17'd44506,17'd42506,
      17'd40600,17'd38791,17'd37073,17'd35442,17'd33892,17'd32420,17'd31020,
      17'd29689,17'd28423,17'd27219,17'd26076,17'd24988,17'd23951,17'd22963,
      17'd22021,17'd21123,17'd20267,17'd19450,17'd18670,17'd17926,17'd17214,
      17'd16534,17'd15886,17'd15266,17'd14674,17'd14108,17'd13566,17'd13049,
      17'd12554,17'd12081,17'd11628,17'd11195,17'd10780,17'd10382,17'd10000,
      17'd9634,17'd9284,17'd8947,17'd8624,17'd8315,17'd8018,17'd7734,17'd7461,
      17'd7199,17'd6948,17'd6707,17'd6475,17'd6253,17'd6039,17'd5834,17'd5636,
      17'd5445,17'd5262,17'd5086,17'd4917,17'd4754,17'd4597,17'd4446,17'd4301,
      17'd4161,17'd4026,17'd3896,17'd3771,17'd3651,17'd3535,17'd3423,17'd3315,
      17'd3211,17'd3111,17'd3014,17'd2922,17'd2834,17'd2748,17'd2666,17'd2586,
      17'd2509,17'd2435,17'd2364,17'd2294,17'd2228,17'd2163,17'd2100,17'd2040,
      17'd1981,17'd1925,17'd1870,17'd1817,17'd1766,17'd1716,17'd1669,17'd1622,
      17'd1578,17'd1535,17'd1493,17'd1452,17'd1413,17'd1375,17'd1338,17'd1303,
      17'd1268,17'd1234,17'd1202,17'd1170,17'd1139,17'd1110,17'd1081,17'd1053,
      17'd1026,17'd999,17'd974,17'd949,17'd925,17'd902,17'd880,17'd858
   };

   // Look up one table entry; indexes past the end read as zero
   function automatic logic [16:0] rom_value(input logic [7:0] idx);
      logic [16:0] val;
      val = 17'd0;
      if (int'(idx) < ROM_SIZE) begin
         val = RES_ROM[idx];
      end
      return val;
   endfunction

endpackage

// ----- hw/rtl/ntct_if.sv -----
// Interfaces: request and response channels of the NTC temperature unit.
interface ntct_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] supply_mv;
   logic [11:0] sensor_mv;
   modport source (output valid, output supply_mv, output sensor_mv, input ready);
   modport sink   (input valid, input supply_mv, input sensor_mv, output ready);
endinterface

interface ntct_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [11:0] temperature_tenths;
   logic [1:0]         status;
   modport source (output valid, output temperature_tenths, output status, input ready);
   modport sink   (input valid, input temperature_tenths, input status, output ready);
endinterface

// ----- hw/rtl/ntc_thermistor_temperature_unit.sv -----
// Top level: pipelined NTC thermistor resistance, table search and interpolation.
//
//  channel   | direction | contents
//  req_chan  | in        | supply_mv[11:0], sensor_mv[11:0]   valid/ready
//  rsp_chan  | out       | temperature_tenths[11:0] signed, status[1:0]
//  csr_*     | in        | csr_wr_en, csr_wr_data[15:0] series resistance
//
// One item enters per cycle while the output is not stalled. The pipeline has 36
// radix-2 steps of the resistance divider, one step per search bit, 17 steps of
// the fraction divider and five setup, scale and round stages.
// Synchronous reset clears valid bits and sets series resistance to 8250.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module ntc_thermistor_temperature_unit #(
   parameter int TABLE_ENTRIES = 136
) (
   input  logic              clock,
   input  logic              reset,
   ntct_req_if.sink          req_chan,
   ntct_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);

   localparam int N  = (TABLE_ENTRIES < ntct_pkg::ROM_SIZE) ? TABLE_ENTRIES
                                                             : ntct_pkg::ROM_SIZE;
   localparam int IW = $clog2(N + 1);
   localparam int D1 = 36;
   localparam int D2 = 17;
   localparam logic signed [11:0] COLD_T = 12'(ntct_pkg::BASE_DEGREE * 10);
   localparam logic signed [11:0] HOT_T  = 12'((ntct_pkg::BASE_DEGREE + N - 1) * 10);

   typedef struct packed {
      logic        zero;
      logic [15:0] ser;
      logic [11:0] den;
      logic [11:0] rem;
      logic [35:0] dq;
   } div1_type;

   typedef struct packed {
      logic               zero;
      logic signed [37:0] rq;
      logic [IW:0]        pos;
   } srch_type;

   typedef struct packed {
      logic [1:0]        status;
      logic signed [9:0] deg;
      logic [24:0]       span;
      logic [25:0]       rem;
      logic [16:0]       q;
   } div2_type;

   logic                 en;
   logic [15:0]          series_ff;
   logic [D1:0]          d1_v_ff;
   div1_type             d1_ff [0:D1];
   div1_type             d1_in [0:D1];
   logic [IW:0]          s_v_ff;
   srch_type             s_ff  [0:IW];
   srch_type             s_in  [0:IW];
   logic [D2:0]          d2_v_ff;
   div2_type             d2_ff [0:D2];
   div2_type             d2_in [0:D2];
   logic                 m_v_ff;
   logic signed [29:0]   m_ff;
   logic signed [29:0]   m_in;
   logic [1:0]           m_stat_ff;
   logic                 out_v_ff;
   logic signed [11:0]   out_t_ff;
   logic [1:0]           out_s_ff;

   // Advance everything unless a result is held
   assign en             = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Series resistance register
   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff <= 16'(ntct_pkg::SERIES_RESET);
      end else if (csr_wr_en) begin
         series_ff <= csr_wr_data;
      end
   end

   // Capture input and form dividend series*supply*256
   always_comb begin
      d1_in[0].zero = (req_chan.sensor_mv == 12'd0);
      d1_in[0].ser  = series_ff;
      d1_in[0].den  = d1_in[0].zero ? 12'd1 : req_chan.sensor_mv;
      d1_in[0].rem  = 12'd0;
      d1_in[0].dq   = {28'(series_ff * req_chan.supply_mv), 8'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff[0] <= 1'b0;
      end else if (en) begin
         d1_v_ff[0] <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff[0] <= d1_in[0];
      end
   end

   // Resistance divider, one quotient bit per stage
   for (genvar k = 0; k < D1; k++) begin : g_div1
      logic [12:0] t;
      logic        ge;
      always_comb begin
         t              = {d1_ff[k].rem, d1_ff[k].dq[35]};
         ge             = (t >= {1'b0, d1_ff[k].den});
         d1_in[k+1]     = d1_ff[k];
         d1_in[k+1].rem = ge ? 12'(t - {1'b0, d1_ff[k].den}) : t[11:0];
         d1_in[k+1].dq  = {d1_ff[k].dq[34:0], ge};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            d1_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            d1_v_ff[k+1] <= d1_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            d1_ff[k+1] <= d1_in[k+1];
         end
      end
   end

   // Subtract series*256 to get signed resistance in Q.8
   always_comb begin
      s_in[0].zero = d1_ff[D1].zero;
      s_in[0].rq   = $signed({2'b00, d1_ff[D1].dq}) - $signed({14'd0, d1_ff[D1].ser, 8'd0});
      s_in[0].pos  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_v_ff[0] <= 1'b0;
      end else if (en) begin
         s_v_ff[0] <= d1_v_ff[D1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[0] <= s_in[0];
      end
   end

   // Binary search: count entries the resistance stays below
   for (genvar k = 0; k < IW; k++) begin : g_srch
      logic [IW:0]        cand;
      logic [7:0]         idx;
      logic signed [37:0] ent;
      always_comb begin
         cand = s_ff[k].pos + (IW+1)'(1 << (IW - 1 - k));
         idx  = 8'(cand - (IW+1)'(1));
         ent  = $signed({13'd0, ntct_pkg::rom_value(idx), 8'd0});
         s_in[k+1] = s_ff[k];
         if ((int'(cand) <= N) && (s_ff[k].rq < ent)) begin
            s_in[k+1].pos = cand;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            s_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            s_v_ff[k+1] <= s_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[k+1] <= s_in[k+1];
         end
      end
   end

   // Classify and set up the fraction division
   always_comb begin
      logic [7:0]  ia;
      logic [7:0]  ib;
      logic [16:0] ra;
      logic [16:0] rb;
      logic [IW:0] p;
      p  = s_ff[IW].pos;
      ia = (p == '0) ? 8'd0 : 8'(p - (IW+1)'(1));
      ib = (int'(p) >= N) ? 8'(N - 1) : 8'(p);
      ra = ntct_pkg::rom_value(ia);
      rb = ntct_pkg::rom_value(ib);
      priority if (s_ff[IW].zero) begin
         d2_in[0].status = ntct_pkg::STAT_ZERO;
      end else if (p == '0) begin
         d2_in[0].status = ntct_pkg::STAT_COLD;
      end else if (int'(p) >= N) begin
         d2_in[0].status = ntct_pkg::STAT_HOT;
      end else begin
         d2_in[0].status = ntct_pkg::STAT_IN_TABLE;
      end
      d2_in[0].deg  = 10'(ntct_pkg::BASE_DEGREE) + $signed({1'b0, 9'(ia)});
      d2_in[0].span = 25'({ra - rb, 8'd0});
      d2_in[0].rem  = 26'({ra, 8'd0} - 25'(s_ff[IW].rq));
      d2_in[0].q    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_v_ff[0] <= 1'b0;
      end else if (en) begin
         d2_v_ff[0] <= s_v_ff[IW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff[0] <= d2_in[0];
      end
   end

   // Fraction divider, first step unshifted for the integer bit
   for (genvar k = 0; k < D2; k++) begin : g_div2
      logic [25:0] t;
      logic        ge;
      always_comb begin
         t              = (k == 0) ? d2_ff[k].rem : {d2_ff[k].rem[24:0], 1'b0};
         ge             = (t >= {1'b0, d2_ff[k].span});
         d2_in[k+1]     = d2_ff[k];
         d2_in[k+1].rem = ge ? 26'(t - {1'b0, d2_ff[k].span}) : t;
         d2_in[k+1].q   = {d2_ff[k].q[15:0], ge};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            d2_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            d2_v_ff[k+1] <= d2_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            d2_ff[k+1] <= d2_in[k+1];
         end
      end
   end

   // Scale by ten and add the rounding half
   always_comb begin
      logic signed [29:0] t;
      t    = 30'($signed({d2_ff[D2].deg, 16'd0})) + $signed({13'd0, d2_ff[D2].q});
      m_in = (t <<< 3) + (t <<< 1) + 30'sd32768;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= d2_v_ff[D2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff      <= m_in;
         m_stat_ff <= d2_ff[D2].status;
      end
   end

   // Round toward zero and apply the clamps
   logic signed [11:0] out_t_in;
   always_comb begin
      logic [29:0] mag;
      mag = m_ff[29] ? 30'(-m_ff) : 30'(m_ff);
      unique case (m_stat_ff)
         ntct_pkg::STAT_IN_TABLE: begin
            out_t_in = m_ff[29] ? 12'(-$signed({1'b0, mag[27:16]})) : 12'(mag[27:16]);
         end
         ntct_pkg::STAT_HOT: begin
            out_t_in = HOT_T;
         end
         default: begin
            out_t_in = COLD_T;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_t_ff <= out_t_in;
         out_s_ff <= m_stat_ff;
      end
   end

   assign rsp_chan.valid              = out_v_ff;
   assign rsp_chan.temperature_tenths = out_t_ff;
   assign rsp_chan.status             = out_s_ff;

   // Checks on pipeline and result consistency
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> (d1_v_ff == $past(d1_v_ff)) && (d2_v_ff == $past(d2_v_ff)))
      else $error("pipeline moved during a stall");

   a_cold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && ((out_s_ff == ntct_pkg::STAT_COLD) || (out_s_ff == ntct_pkg::STAT_ZERO))
      |-> (out_t_ff == COLD_T))
      else $error("cold clamp value wrong");

   a_range: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && (out_s_ff == ntct_pkg::STAT_IN_TABLE)
      |-> (out_t_ff >= COLD_T) && (out_t_ff <= HOT_T))
      else $error("interpolated result out of range");

   a_span: assert property (@(posedge clock) disable iff (reset)
      d2_v_ff[0] && (d2_ff[0].status == ntct_pkg::STAT_IN_TABLE) |-> (d2_ff[0].span != '0))
      else $error("zero interpolation span");

endmodule
